// ----- hw/rtl/sha256c_pkg.sv -----
// Shared types, constants and round functions of the SHA-256 compression engine.
package sha256c_pkg;

  typedef logic [0:7][31:0] vars_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_ROUND,
    ST_UPDATE,
    ST_DRAIN
  } state_t;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned DIGEST_WORDS = 8;

  localparam vars_t INIT_HASH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- hw/rtl/sha256c_round.sv -----
// One SHA-256 round and one schedule expansion step, reused every cycle.
module sha256c_round (
  input  sha256c_pkg::vars_t vars_in,
  input  logic [31:0]        w_t,
  input  logic [31:0]        k_t,
  input  logic [31:0]        w_1,
  input  logic [31:0]        w_9,
  input  logic [31:0]        w_14,
  output sha256c_pkg::vars_t vars_out,
  output logic [31:0]        w_new
);

  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] choose, major, t1, t2;

  assign {a, b, c, d, e, f, g, h} = vars_in;

  assign choose = (e & f) ^ (~e & g);
  assign major  = (a & b) ^ (a & c) ^ (b & c);
  assign t1 = h + sha256c_pkg::big_sigma1(e) + choose + k_t + w_t;
  assign t2 = sha256c_pkg::big_sigma0(a) + major;

  assign vars_out = '{t1 + t2, a, b, c, d + t1, e, f, g};

  // Word sixteen places ahead of the one used in this round.
  assign w_new = sha256c_pkg::small_sigma1(w_14) + w_9 + sha256c_pkg::small_sigma0(w_1) + w_t;

endmodule

// ----- hw/rtl/sha256_compression_top.sv -----
// Top level of the SHA-256 compression engine: word intake, round sequencer, digest output.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one padded, big-endian 32-bit message word
//   per handshake. Set new_message on the first word of a message to reload the initial
//   hash value; a flag in the middle of a block drops the words gathered so far.
//   After every sixteenth word the engine compresses the block: its 64 rounds run one after
//   another on one shared round unit, then an update state adds into the chaining digest.
//   Output channel (out_valid/out_ready) then carries the eight digest words, word_index
//   0 to 7, with last set on word 7.
// The first digest word is offered once the rounds and the update state are through.
// Throughput is set by the 64-round loop; when both sides move at once, eight words of the
//   next block are taken while the eight digest words drain.
// During the rounds in_ready is low. While digest words drain, in_ready stays high for
//   words that neither start a message nor complete a block.
// A stalled receiver holds the current digest word steady until it is taken.
// Reset: sync, active high; clears the word count and sequencer, loads the initial hash.
module sha256_compression_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sha256c_pkg::WORD_W-1:0] message_word,
  input  logic                           new_message,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sha256c_pkg::WORD_W-1:0] digest_word,
  output logic [2:0]                     word_index,
  output logic                           last
);

  sha256c_pkg::state_t state, state_next;

  logic [3:0]        word_count;
  logic [5:0]        round;
  logic [2:0]        out_idx;
  logic [31:0]       win [sha256c_pkg::BLOCK_WORDS];
  sha256c_pkg::vars_t vars, vars_out, digest;
  logic [31:0]       w_new;

  logic in_acc, out_acc, start;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  // The sixteenth word of a block kicks off compression.
  assign start   = in_acc && !new_message && (word_count == 4'd15);

  sha256c_round u_round (
    .vars_in  (vars),
    .w_t      (win[0]),
    .k_t      (sha256c_pkg::ROUND_K[round]),
    .w_1      (win[1]),
    .w_9      (win[9]),
    .w_14     (win[14]),
    .vars_out (vars_out),
    .w_new    (w_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256c_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      sha256c_pkg::ST_COLLECT: begin
        in_ready = 1'b1;
        if (start) state_next = sha256c_pkg::ST_ROUND;
      end
      sha256c_pkg::ST_ROUND: begin
        if (round == 6'd63) state_next = sha256c_pkg::ST_UPDATE;
      end
      sha256c_pkg::ST_UPDATE: begin
        state_next = sha256c_pkg::ST_DRAIN;
      end
      sha256c_pkg::ST_DRAIN: begin
        out_valid = 1'b1;
        // Hold off words that would disturb the digest being drained.
        in_ready  = !new_message && (word_count != 4'd15);
        if (out_acc && out_idx == 3'd7) state_next = sha256c_pkg::ST_COLLECT;
      end
      default: state_next = sha256c_pkg::ST_COLLECT;
    endcase
  end

  // Word count, digest and output index.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
      digest     <= sha256c_pkg::INIT_HASH;
      out_idx    <= '0;
    end else begin
      if (in_acc) begin
        if (new_message) begin
          word_count <= 4'd1;
          digest     <= sha256c_pkg::INIT_HASH;
        end else begin
          word_count <= word_count + 4'd1;
        end
      end
      if (state == sha256c_pkg::ST_UPDATE) begin
        for (int i = 0; i < sha256c_pkg::DIGEST_WORDS; i++) begin
          digest[i] <= digest[i] + vars[i];
        end
        out_idx <= '0;
      end else if (out_acc) begin
        out_idx <= out_idx + 3'd1;
      end
    end
  end

  // Round counter, working variables and schedule window.
  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
    end else if (start) begin
      round <= '0;
    end else if (state == sha256c_pkg::ST_ROUND) begin
      round <= round + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vars <= digest;
    end else if (state == sha256c_pkg::ST_ROUND) begin
      vars <= vars_out;
    end
  end

  // Advance the window by one word per accepted word and per round.
  always_ff @(posedge clk) begin
    if (in_acc || state == sha256c_pkg::ST_ROUND) begin
      for (int i = 0; i < sha256c_pkg::BLOCK_WORDS - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[sha256c_pkg::BLOCK_WORDS-1] <= in_acc ? message_word[31:0] : w_new;
    end
  end

  assign digest_word = digest[out_idx];
  assign word_index  = out_idx;
  assign last        = (out_idx == 3'd7);

endmodule

// ----- hw/rtl/sha256c_checker.sv -----
// Port-level assertions for the SHA-256 compression engine, bound to its top level.
module sha256c_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        new_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest word changed while stalled");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (word_index == 3'd7)))
    else $error("last flag does not match word index");

  a_drain_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest words out of order or broken burst");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && new_message |-> !in_ready)
    else $error("new message taken while digest drains");

endmodule

bind sha256_compression_top sha256c_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .new_message (new_message),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .digest_word (digest_word),
  .word_index  (word_index),
  .last        (last)
);
